>>> hdl/gcd_pkg.sv
// Package for the haversine distance pipeline: payload structs, fixed-point
// constants, the arctangent table and CORDIC step counts. No dependencies.
`default_nettype none
package gcd_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int ANGLE_FRACTION_BITS = 20;
    localparam int QB = 30;
    localparam int RADIUS_W = 23;
    localparam int DIST_W = 35;
    localparam int ISQRT_STEPS = 31;

    localparam logic signed [63:0] ONE_Q = 64'sd1 <<< QB;
    localparam logic signed [63:0] PI_Q60 = 64'sh3243F6A8885A308D;
    localparam logic signed [63:0] PI_Q30 = (PI_Q60 + (64'sd1 <<< 29)) >>> 30;
    localparam logic signed [63:0] DEG2RAD_K = (PI_Q60 / 180 + (64'sd1 <<< 27)) >>> 28;
    localparam logic signed [33:0] INV_GAIN = 34'sh026DD3B6A;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 23'd6372800;

    localparam logic signed [33:0] L90 = 34'sd90 <<< ANGLE_FRACTION_BITS;
    localparam logic signed [33:0] L180 = 34'sd180 <<< ANGLE_FRACTION_BITS;
    localparam logic signed [33:0] L360 = 34'sd360 <<< ANGLE_FRACTION_BITS;

    typedef struct packed {
        logic signed [31:0] lat_a;
        logic signed [31:0] lon_a;
        logic signed [31:0] lat_b;
        logic signed [31:0] lon_b;
    } gcd_in_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance_mm;
        logic              bad_point;
    } gcd_out_t;

    function automatic logic signed [63:0] pow2_over(input int e, input int d);
        logic [63:0] num;
        logic [63:0] quo;
        logic [63:0] rem;
        num = 64'd1 << e;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= 64'(d)) begin
                rem = rem - 64'(d);
                quo[b] = 1'b1;
            end
        end
        return $signed(quo);
    endfunction

    function automatic logic signed [33:0] atan_entry(input int i);
        logic signed [63:0] sum;
        logic signed [63:0] term;
        int e;
        sum = 64'sd0;
        if (i == 0) begin
            return 34'((PI_Q60 + (64'sd1 <<< 31)) >>> 32);
        end
        for (int k = 0; k < 31; k++) begin
            e = 60 - i * (2 * k + 1);
            if (e >= 0) begin
                term = pow2_over(e, 2 * k + 1);
                sum = k[0] ? sum - term : sum + term;
            end
        end
        return 34'((sum + (64'sd1 <<< 29)) >>> 30);
    endfunction

endpackage
`default_nettype wire

>>> hdl/great_circle_distance_top.sv
// Haversine great-circle distance pipeline top level.
// Pipelined front, rotate, mix, sqrt, vector and back stages, one pair per cycle while not
// stalled, set by the unrolled CORDIC and square-root chains. A stall freezes all stages.
// Reset (synchronous, aresetn low) clears all valid bits and loads the default radius.
// Depends on gcd_pkg.
`default_nettype none
module great_circle_distance_top (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           s_valid,
    output logic                          s_ready,
    input  gcd_pkg::gcd_in_t              s_data,
    output logic                          m_valid,
    input  wire                           m_ready,
    output gcd_pkg::gcd_out_t             m_data,
    input  wire                           cfg_we,
    input  wire [gcd_pkg::RADIUS_W-1:0]   cfg_data
);
    import gcd_pkg::*;

    localparam int NR = CORDIC_STEPS;
    localparam int NS = ISQRT_STEPS;
    // stage indexes: 0..2 front, 3..3+NR-1 rotate, then mix, sqrt, vector, back
    localparam int S_ROT = 3;
    localparam int S_MIX = S_ROT + NR;
    localparam int S_SQ = S_MIX + 3;
    localparam int S_VEC = S_SQ + NS;
    localparam int S_END = S_VEC + NR + 3;

    logic [RADIUS_W-1:0] radius_reg;
    logic [S_END-1:0] vld_reg;
    logic adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= RADIUS_RESET;
        end else if (cfg_we) begin
            radius_reg <= cfg_data;
        end
    end

    assign adv = !m_valid || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[S_END-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[S_END-2:0], s_valid};
        end
    end

    // front: range check, differences, radians
    logic bad_reg [S_END];
    logic signed [33:0] dlat0_reg, dlon0_reg, lata0_reg, latb0_reg;
    logic signed [63:0] p_reg [4];
    logic signed [33:0] z0_reg [4];
    logic signed [33:0] dlon_f;
    logic bad_in;

    always_comb begin
        bad_in = (34'(s_data.lat_a) < -L90) || (34'(s_data.lat_a) > L90) ||
                 (34'(s_data.lat_b) < -L90) || (34'(s_data.lat_b) > L90) ||
                 (34'(s_data.lon_a) < -L180) || (34'(s_data.lon_a) > L180) ||
                 (34'(s_data.lon_b) < -L180) || (34'(s_data.lon_b) > L180);
        dlon_f = dlon0_reg;
        if (dlon0_reg > L180) begin
            dlon_f = L360 - dlon0_reg;
        end else if (dlon0_reg < -L180) begin
            dlon_f = -L360 - dlon0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            bad_reg[0] <= bad_in;
            dlat0_reg <= 34'(s_data.lat_b) - 34'(s_data.lat_a);
            dlon0_reg <= 34'(s_data.lon_b) - 34'(s_data.lon_a);
            lata0_reg <= 34'(s_data.lat_a);
            latb0_reg <= 34'(s_data.lat_b);
            bad_reg[1] <= bad_reg[0];
            p_reg[0] <= 64'(dlat0_reg) * DEG2RAD_K;
            p_reg[1] <= 64'(dlon_f) * DEG2RAD_K;
            p_reg[2] <= 64'(lata0_reg) * DEG2RAD_K;
            p_reg[3] <= 64'(latb0_reg) * DEG2RAD_K;
            bad_reg[2] <= bad_reg[1];
            for (int j = 0; j < 4; j++) begin
                z0_reg[j] <= (j < 2)
                    ? 34'((p_reg[j] + (64'sd1 <<< (ANGLE_FRACTION_BITS + 2))) >>>
                          (ANGLE_FRACTION_BITS + 3))
                    : 34'((p_reg[j] + (64'sd1 <<< (ANGLE_FRACTION_BITS + 1))) >>>
                          (ANGLE_FRACTION_BITS + 2));
            end
        end
    end

    // rotation CORDIC, four lanes
    logic signed [33:0] rx_reg [NR+1][4];
    logic signed [33:0] ry_reg [NR+1][4];
    logic signed [33:0] rz_reg [NR+1][4];

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            rx_reg[0][j] = INV_GAIN;
            ry_reg[0][j] = '0;
            rz_reg[0][j] = z0_reg[j];
        end
    end

    for (genvar i = 0; i < NR; i++) begin : g_rot
        localparam logic signed [33:0] ATAN_I = atan_entry(i);
        always_ff @(posedge aclk) begin
            if (adv) begin
                bad_reg[S_ROT+i] <= bad_reg[S_ROT+i-1];
                for (int j = 0; j < 4; j++) begin
                    if (!rz_reg[i][j][33]) begin
                        rx_reg[i+1][j] <= rx_reg[i][j] - (ry_reg[i][j] >>> i);
                        ry_reg[i+1][j] <= ry_reg[i][j] + (rx_reg[i][j] >>> i);
                        rz_reg[i+1][j] <= rz_reg[i][j] - ATAN_I;
                    end else begin
                        rx_reg[i+1][j] <= rx_reg[i][j] + (ry_reg[i][j] >>> i);
                        ry_reg[i+1][j] <= ry_reg[i][j] - (rx_reg[i][j] >>> i);
                        rz_reg[i+1][j] <= rz_reg[i][j] + ATAN_I;
                    end
                end
            end
        end
    end

    // haversine term h
    logic signed [67:0] aa_w, bb_w, cc_w, hb_w;
    logic signed [33:0] aa_reg, aa1_reg, bb_reg, cc_reg, hb_reg;
    logic signed [34:0] h_sum;
    logic [30:0] h_reg;

    assign aa_w = 68'(ry_reg[NR][0]) * 68'(ry_reg[NR][0]) + (68'sd1 <<< (QB - 1));
    assign bb_w = 68'(ry_reg[NR][1]) * 68'(ry_reg[NR][1]) + (68'sd1 <<< (QB - 1));
    assign cc_w = 68'(rx_reg[NR][2]) * 68'(rx_reg[NR][3]) + (68'sd1 <<< (QB - 1));
    assign hb_w = 68'(cc_reg) * 68'(bb_reg) + (68'sd1 <<< (QB - 1));
    assign h_sum = 35'(aa1_reg) + 35'(hb_reg);

    always_ff @(posedge aclk) begin
        if (adv) begin
            bad_reg[S_MIX] <= bad_reg[S_MIX-1];
            aa_reg <= 34'(aa_w >>> QB);
            bb_reg <= 34'(bb_w >>> QB);
            cc_reg <= 34'(cc_w >>> QB);
            bad_reg[S_MIX+1] <= bad_reg[S_MIX];
            hb_reg <= 34'(hb_w >>> QB);
            aa1_reg <= aa_reg;
            bad_reg[S_MIX+2] <= bad_reg[S_MIX+1];
            if (h_sum < 0) begin
                h_reg <= '0;
            end else if (h_sum > 35'(ONE_Q)) begin
                h_reg <= 31'(ONE_Q);
            end else begin
                h_reg <= 31'(h_sum);
            end
        end
    end

    // two square roots, one result bit per stage
    logic [60:0] sv_reg [NS+1][2];
    logic [30:0] sr_reg [NS+1][2];
    logic [61:0] tr_w [NS][2];

    always_comb begin
        sv_reg[0][0] = {h_reg[30:0], 30'd0};
        sv_reg[0][1] = {31'(ONE_Q) - h_reg, 30'd0};
        sr_reg[0][0] = '0;
        sr_reg[0][1] = '0;
    end

    for (genvar i = 0; i < NS; i++) begin : g_sq
        localparam int B = NS - 1 - i;
        for (genvar j = 0; j < 2; j++) begin : g_l
            assign tr_w[i][j] = ({31'd0, sr_reg[i][j]} << (B + 1)) + (62'd1 << (2 * B));
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                bad_reg[S_SQ+i] <= bad_reg[S_SQ+i-1];
                for (int j = 0; j < 2; j++) begin
                    if ({1'b0, sv_reg[i][j]} >= tr_w[i][j]) begin
                        sv_reg[i+1][j] <= 61'({1'b0, sv_reg[i][j]} - tr_w[i][j]);
                        sr_reg[i+1][j] <= sr_reg[i][j] | (31'd1 << B);
                    end else begin
                        sv_reg[i+1][j] <= sv_reg[i][j];
                        sr_reg[i+1][j] <= sr_reg[i][j];
                    end
                end
            end
        end
    end

    // vectoring CORDIC for atan2(s, c)
    logic signed [34:0] vx_reg [NR+1];
    logic signed [34:0] vy_reg [NR+1];
    logic signed [34:0] vz_reg [NR+1];

    assign vx_reg[0] = 35'(sr_reg[NS][1]);
    assign vy_reg[0] = 35'(sr_reg[NS][0]);
    assign vz_reg[0] = '0;

    for (genvar i = 0; i < NR; i++) begin : g_vec
        localparam logic signed [33:0] ATAN_I = atan_entry(i);
        always_ff @(posedge aclk) begin
            if (adv) begin
                bad_reg[S_VEC+i] <= bad_reg[S_VEC+i-1];
                if (vy_reg[i] > 0) begin
                    vx_reg[i+1] <= vx_reg[i] + (vy_reg[i] >>> i);
                    vy_reg[i+1] <= vy_reg[i] - (vx_reg[i] >>> i);
                    vz_reg[i+1] <= vz_reg[i] + 35'(ATAN_I);
                end else begin
                    vx_reg[i+1] <= vx_reg[i] - (vy_reg[i] >>> i);
                    vy_reg[i+1] <= vy_reg[i] + (vx_reg[i] >>> i);
                    vz_reg[i+1] <= vz_reg[i] - 35'(ATAN_I);
                end
            end
        end
    end

    // theta * R, then scale to millimetres
    logic signed [35:0] th_w;
    logic [31:0] th_reg;
    logic [54:0] p_mul_reg;
    logic [DIST_W-1:0] mm_reg;
    logic [63:0] mm_w;

    always_comb begin
        th_w = 36'(vz_reg[NR]) <<< 1;
        mm_w = 64'(p_mul_reg >> QB) * 64'd1000 +
               ((64'(p_mul_reg[QB-1:0]) * 64'd1000 + (64'd1 << (QB - 1))) >> QB);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            bad_reg[S_END-3] <= bad_reg[S_END-4];
            if (th_w < 0) begin
                th_reg <= '0;
            end else if (th_w > 36'(PI_Q30)) begin
                th_reg <= 32'(PI_Q30);
            end else begin
                th_reg <= 32'(th_w);
            end
            bad_reg[S_END-2] <= bad_reg[S_END-3];
            p_mul_reg <= 55'(th_reg) * 55'(radius_reg);
            bad_reg[S_END-1] <= bad_reg[S_END-2];
            mm_reg <= bad_reg[S_END-2] ? '0 : DIST_W'(mm_w);
        end
    end

    assign m_data.distance_mm = mm_reg;
    assign m_data.bad_point = bad_reg[S_END-1];

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed during stall");
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.bad_point |-> m_data.distance_mm == '0)
        else $error("bad point with nonzero distance");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

endmodule
`default_nettype wire
